### rtl/core/hilbert_index_converter_assert.svh
// ----------------------------------------------------------------------------
// hilbert_index_converter_assert.svh
// Assertion macros shared by the Hilbert index converter RTL.
// ----------------------------------------------------------------------------
`ifndef HILBERT_INDEX_CONVERTER_ASSERT_SVH
`define HILBERT_INDEX_CONVERTER_ASSERT_SVH

// Condition checked at every clock edge outside reset.
`define HIC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent this cycle implies consequent next cycle.
`define HIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/hic_pkg.sv
// ----------------------------------------------------------------------------
// hic_pkg
// Shared types, constants and the per-level Hilbert transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hic_pkg;

  localparam int MaxOrder   = 16;
  localparam int CoordBits  = 16;
  localparam int IndexBits  = 32;
  localparam int OrderBits  = 5;
  localparam int NumStages  = 4;
  localparam int LvlPerStg  = 4;
  localparam logic [OrderBits-1:0] OrderReset = 5'd3;

  localparam logic ActToIndex  = 1'b0;
  localparam logic ActToCoords = 1'b1;

  typedef struct packed {
    logic                 act;  // 0: coords -> index, 1: index -> coords
    logic                 odd;  // effective order is odd
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [IndexBits-1:0] d;
  } hic_item_t;

  // One level of either conversion. kup is the level counted from the
  // bottom; coords->index walks from the top, so it uses the complement.
  function automatic hic_item_t level_step(hic_item_t it, logic [3:0] kup);
    logic [3:0]           k;
    logic [CoordBits-1:0] m;
    logic [CoordBits-1:0] xs;
    logic [CoordBits-1:0] ys;
    logic [CoordBits-1:0] tmp;
    logic                 rx;
    logic                 ry;
    k = (it.act == ActToCoords) ? kup : ~kup;
    m = (CoordBits'(1) << k) - CoordBits'(1);
    if (it.act == ActToIndex) begin
      rx = it.x[k];
      ry = it.y[k];
      it.d[{k, 1'b1}] = rx;
      it.d[{k, 1'b0}] = rx ^ ry;
      xs = it.x & m;
      ys = it.y & m;
    end else begin
      rx = it.d[{k, 1'b1}];
      ry = it.d[{k, 1'b0}] ^ rx;
      xs = it.x;
      ys = it.y;
    end
    if (!ry) begin
      if (rx) begin
        xs = ~xs & m;
        ys = ~ys & m;
      end
      tmp = xs;
      xs  = ys;
      ys  = tmp;
    end
    if (it.act == ActToCoords) begin
      xs[k] = rx;
      ys[k] = ry;
    end
    it.x = xs;
    it.y = ys;
    return it;
  endfunction

endpackage

`default_nettype wire

### rtl/core/hic_prep.sv
// ----------------------------------------------------------------------------
// hic_prep
// Input register: masks fields to the grid order and seeds the level state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hic_prep (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 action,
  input  wire logic [hic_pkg::CoordBits-1:0]        in_x,
  input  wire logic [hic_pkg::CoordBits-1:0]        in_y,
  input  wire logic [hic_pkg::IndexBits-1:0]        in_index,
  input  wire logic [hic_pkg::OrderBits-1:0]        grid_order,
  output logic                                      out_valid,
  output hic_pkg::hic_item_t                        out_item,
  input  wire logic                                 out_ready
);
`include "hilbert_index_converter_assert.svh"

  logic [hic_pkg::OrderBits-1:0] ord;
  logic [hic_pkg::CoordBits-1:0] cmask;
  logic [hic_pkg::IndexBits-1:0] imask;
  logic [hic_pkg::CoordBits-1:0] xm;
  logic [hic_pkg::CoordBits-1:0] ym;
  hic_pkg::hic_item_t            item_next;

  assign ord = (grid_order > hic_pkg::OrderBits'(hic_pkg::MaxOrder)) ?
               hic_pkg::OrderBits'(hic_pkg::MaxOrder) : grid_order;

  always_comb begin
    for (int i = 0; i < hic_pkg::CoordBits; i++) begin
      cmask[i] = (hic_pkg::OrderBits'(i) < ord);
    end
    for (int i = 0; i < hic_pkg::IndexBits; i++) begin
      imask[i] = ((hic_pkg::OrderBits + 1)'(i) < {ord, 1'b0});
    end
  end

  assign xm = in_x & cmask;
  assign ym = in_y & cmask;

  // Levels above the order run as plain swaps; pre-swap on odd order
  // cancels them for coords -> index.
  always_comb begin
    item_next.act = action;
    item_next.odd = ord[0];
    if (action == hic_pkg::ActToCoords) begin
      item_next.x = '0;
      item_next.y = '0;
      item_next.d = in_index & imask;
    end else begin
      item_next.x = ord[0] ? ym : xm;
      item_next.y = ord[0] ? xm : ym;
      item_next.d = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

  `HIC_ASSERT(a_prep_seed, !out_valid || (out_item.act ? (out_item.x == '0 && out_item.y == '0) : (out_item.d == '0)), "prep: seeded item has stray bits")

endmodule

`default_nettype wire

### rtl/core/hic_stage.sv
// ----------------------------------------------------------------------------
// hic_stage
// Pipeline stage: four Hilbert levels, registered, with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hic_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [1:0]         stage_id,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hic_pkg::hic_item_t in_item,
  output logic                    out_valid,
  output hic_pkg::hic_item_t      out_item,
  input  wire logic               out_ready
);
`include "hilbert_index_converter_assert.svh"

  hic_pkg::hic_item_t item_next;

  // Levels 4*stage_id .. +3 counted from the bottom.
  always_comb begin
    item_next = in_item;
    for (int j = 0; j < hic_pkg::LvlPerStg; j++) begin
      item_next = hic_pkg::level_step(item_next, {stage_id, 2'(j)});
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

  `HIC_ASSERT_NEXT(a_stage_hold, out_valid && !out_ready, out_valid && $stable(out_item), "stage: stalled item changed")
  `HIC_ASSERT_NEXT(a_stage_mode, out_valid && !out_ready, out_item.act == $past(out_item.act), "stage: stalled item action changed")

endmodule

`default_nettype wire

### rtl/core/hilbert_index_converter.sv
// ----------------------------------------------------------------------------
// hilbert_index_converter
// Hilbert curve conversion between (x, y) and curve index, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one item: action, in_x, in_y,
//   in_index. Action 0 turns (in_x, in_y) into out_index; action 1 turns
//   in_index into (out_x, out_y). Fields the action does not produce are 0.
//   Output channel out_valid/out_ready returns exactly one item per input,
//   in order.
//   cfg_we/cfg_wdata write grid_order (reset value 3, values above 16 act
//   as 16). Write it only while no item is in flight.
//   Structure: five register stages, one input register plus four stages of
//   four levels each; the accepting edge loads the first, and the item then
//   moves through the four level stages in order before out_valid rises.
//   Throughput: one item per cycle while the receiver does not stall, set by
//   the level pipeline, which always runs all 16 levels whatever the order.
//   Reset (rst, synchronous) empties the pipeline and restores grid_order.
//   When the receiver stalls, each stage holds its item and the stall
//   ripples back; in_ready drops only once every stage is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hilbert_index_converter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [hic_pkg::OrderBits-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          action,
  input  wire logic [hic_pkg::CoordBits-1:0] in_x,
  input  wire logic [hic_pkg::CoordBits-1:0] in_y,
  input  wire logic [hic_pkg::IndexBits-1:0] in_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [hic_pkg::IndexBits-1:0]      out_index,
  output logic [hic_pkg::CoordBits-1:0]      out_x,
  output logic [hic_pkg::CoordBits-1:0]      out_y
);
`include "hilbert_index_converter_assert.svh"

  // Grid order register.
  logic [hic_pkg::OrderBits-1:0] grid_order;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_order <= hic_pkg::OrderReset;
    end else if (cfg_we) begin
      grid_order <= cfg_wdata;
    end
  end

  // Pipeline links: index 0 is the prep register, 1..4 the level stages.
  logic               vld [hic_pkg::NumStages+1];
  logic               rdy [hic_pkg::NumStages+1];
  hic_pkg::hic_item_t itm [hic_pkg::NumStages+1];

  hic_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_index   (in_index),
    .grid_order (grid_order),
    .out_valid  (vld[0]),
    .out_item   (itm[0]),
    .out_ready  (rdy[0])
  );

  // Stage g handles levels 4g..4g+3 from the bottom (index -> coords) or
  // the mirrored levels from the top (coords -> index).
  for (genvar g = 0; g < hic_pkg::NumStages; g++) begin : g_stage
    hic_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .stage_id  (2'(g)),
      .in_valid  (vld[g]),
      .in_ready  (rdy[g]),
      .in_item   (itm[g]),
      .out_valid (vld[g+1]),
      .out_item  (itm[g+1]),
      .out_ready (rdy[g+1])
    );
  end

  assign rdy[hic_pkg::NumStages] = out_ready;
  assign out_valid               = vld[hic_pkg::NumStages];

  // Upper levels beyond the order act as swaps; an odd order leaves the
  // coordinates exchanged, undone here.
  hic_pkg::hic_item_t last;
  assign last = itm[hic_pkg::NumStages];

  always_comb begin
    if (last.act == hic_pkg::ActToCoords) begin
      out_index = '0;
      out_x     = last.odd ? last.y : last.x;
      out_y     = last.odd ? last.x : last.y;
    end else begin
      out_index = last.d;
      out_x     = '0;
      out_y     = '0;
    end
  end

  // in_ready low only when the whole pipe is backed up by the receiver.
  `HIC_ASSERT(a_top_backpressure, in_ready || (out_valid && !out_ready), "top: input stalled with output free")

endmodule

`default_nettype wire

### tb/hilbert_index_converter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilbert_index_converter_checker
// Watches both channels and the order register of the Hilbert converter.
// It predicts each result from its own copy of grid_order and compares
// results in order.
// ----------------------------------------------------------------------------
module hilbert_index_converter_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hic_pkg::OrderBits-1:0] cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          action,
  input  logic [hic_pkg::CoordBits-1:0] in_x,
  input  logic [hic_pkg::CoordBits-1:0] in_y,
  input  logic [hic_pkg::IndexBits-1:0] in_index,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [hic_pkg::IndexBits-1:0] out_index,
  input  logic [hic_pkg::CoordBits-1:0] out_x,
  input  logic [hic_pkg::CoordBits-1:0] out_y,
  output int                            mismatches,
  output int                            outstanding,
  output int                            results_seen
);
  import hic_pkg::*;

  typedef struct packed {
    logic [IndexBits-1:0] index;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
  } curve_result_t;

  logic [OrderBits-1:0] order_shadow;
  curve_result_t        pending_results[$];

  // Both directions of the curve mapping at the given grid order.
  function automatic curve_result_t map_curve(logic act, logic [CoordBits-1:0] xi,
                                              logic [CoordBits-1:0] yi,
                                              logic [IndexBits-1:0] di,
                                              logic [OrderBits-1:0] ord_raw);
    curve_result_t        res;
    int                   ord;
    logic [CoordBits-1:0] px;
    logic [CoordBits-1:0] py;
    logic [CoordBits-1:0] lm;
    logic [CoordBits-1:0] tmp;
    logic [IndexBits-1:0] rest;
    logic                 rx;
    logic                 ry;
    ord = (ord_raw > MaxOrder) ? MaxOrder : int'(ord_raw);
    res = '0;
    if (act == ActToIndex) begin
      px = xi;
      py = yi;
      for (int k = ord - 1; k >= 0; k--) begin
        lm = (CoordBits'(1) << k) - CoordBits'(1);
        rx = px[k];
        ry = py[k];
        // quadrant code (3*rx)^ry is {rx, rx^ry}
        res.index = res.index + (IndexBits'({rx, rx ^ ry}) << (2 * k));
        px = px & lm;
        py = py & lm;
        if (!ry) begin
          if (rx) begin
            px = ~px & lm;
            py = ~py & lm;
          end
          tmp = px;
          px  = py;
          py  = tmp;
        end
      end
    end else begin
      px   = '0;
      py   = '0;
      rest = di;
      for (int k = 0; k < ord; k++) begin
        lm = (CoordBits'(1) << k) - CoordBits'(1);
        rx = rest[1];
        ry = rest[0] ^ rx;
        if (!ry) begin
          if (rx) begin
            px = ~px & lm;
            py = ~py & lm;
          end
          tmp = px;
          px  = py;
          py  = tmp;
        end
        px[k] = rx;
        py[k] = ry;
        rest  = rest >> 2;
      end
      res.x = px;
      res.y = py;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    curve_result_t got;
    curve_result_t want;
    if (rst) begin
      order_shadow <= OrderReset;
      pending_results.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) order_shadow <= cfg_wdata;
      if (in_valid && in_ready)
        pending_results.push_back(map_curve(action, in_x, in_y, in_index, order_shadow));
      if (out_valid && out_ready) begin
        got = '{index: out_index, x: out_x, y: out_y};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected item: index %h x %h y %h",
                     $realtime, got.index, got.x, got.y);
        end else begin
          want = pending_results.pop_front();
          results_seen++;
          if (got.index !== want.index || got.x !== want.x || got.y !== want.y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch: expected index %h x %h y %h, got index %h x %h y %h",
                       $realtime, want.index, want.x, want.y, got.index, got.x, got.y);
          end
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

### tb/hilbert_index_converter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilbert_index_converter_tb
// Drives the Hilbert converter through directed corner items and random
// phases at many grid orders, with random idling on both channels and one
// long output stall; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module hilbert_index_converter_tb;
  import hic_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [OrderBits-1:0] cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 action;
  logic [CoordBits-1:0] in_x;
  logic [CoordBits-1:0] in_y;
  logic [IndexBits-1:0] in_index;
  logic                 out_valid;
  logic                 out_ready;
  logic [IndexBits-1:0] out_index;
  logic [CoordBits-1:0] out_x;
  logic [CoordBits-1:0] out_y;

  int mismatches;
  int outstanding;
  int results_seen;

  // Stimulus bookkeeping, also read by the receiver process.
  int items_sent    = 0;
  int to_index_cnt  = 0;
  int to_coords_cnt = 0;
  int order_writes  = 0;
  bit sender_steady = 1'b0;

  always #4 clk = ~clk;

  hilbert_index_converter u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_index  (in_index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_index (out_index),
    .out_x     (out_x),
    .out_y     (out_y)
  );

  hilbert_index_converter_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_index     (in_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_index    (out_index),
    .out_x        (out_x),
    .out_y        (out_y),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  // Offer one item at a falling edge, after a random idle gap unless the
  // sender is in its steady stretch. Valid stays up until the rising edge
  // that accepts the item; in_ready is read there before the block updates.
  task automatic offer_item(logic act, logic [CoordBits-1:0] x, logic [CoordBits-1:0] y,
                            logic [IndexBits-1:0] d);
    @(negedge clk);
    while (!sender_steady && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    in_x     <= x;
    in_y     <= y;
    in_index <= d;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (act == ActToIndex) to_index_cnt++;
    else                   to_coords_cnt++;
  endtask

  // grid_order is only written with nothing in flight: drop valid, wait
  // for every expected result, then pulse the write enable.
  task automatic write_grid_order(logic [OrderBits-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    order_writes++;
  endtask

  // Receiver: random back-pressure, one long hold-off while the sender
  // keeps offering (fills the pipeline and stalls in_ready), and a window
  // with no back-pressure at all.
  initial begin
    int  hold_left;
    bit  hold_done;
    out_ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent >= 450) begin
        hold_done = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (items_sent >= 1100 && items_sent < 1400) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int          phase_orders[6];
    int          ord;
    int          eff;
    longint      cmask;
    longint      imask;
    logic        act;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rd;

    phase_orders = '{2, 16, 7, 31, 17, 0};
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    action    = ActToIndex;
    in_x      = '0;
    in_y      = '0;
    in_index  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset order 3: corners, all-ones fields, garbage in the
    // fields the action ignores.
    offer_item(ActToIndex,  16'h0000, 16'h0000, 32'h0000_0000);
    offer_item(ActToIndex,  16'h0007, 16'h0007, 32'h0000_0000);
    offer_item(ActToIndex,  16'h0007, 16'h0000, 32'h0000_0000);
    offer_item(ActToIndex,  16'h0000, 16'h0007, 32'h0000_0000);
    offer_item(ActToIndex,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    offer_item(ActToCoords, 16'h0000, 16'h0000, 32'h0000_0000);
    offer_item(ActToCoords, 16'h0000, 16'h0000, 32'h0000_003F);
    offer_item(ActToCoords, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    offer_item(ActToCoords, 16'h1234, 16'h5678, 32'h0000_002A);

    // 1x1 grid: everything comes back zero.
    write_grid_order(5'd0);
    offer_item(ActToIndex,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    offer_item(ActToCoords, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);

    // Out-of-range order saturates to 16.
    write_grid_order(5'd31);
    offer_item(ActToIndex,  16'hFFFF, 16'hFFFF, 32'h0000_0000);
    offer_item(ActToIndex,  16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    offer_item(ActToCoords, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    offer_item(ActToCoords, 16'hFFFF, 16'hFFFF, 32'h8000_0000);
    offer_item(ActToIndex,  16'hFFFF, 16'h0000, 32'h0000_0000);

    write_grid_order(5'd16);
    offer_item(ActToCoords, 16'h0000, 16'h0000, 32'h1234_5678);
    offer_item(ActToIndex,  16'h8000, 16'h0001, 32'h0000_0000);

    // Smallest real grid, 2x2.
    write_grid_order(5'd1);
    offer_item(ActToIndex,  16'h0001, 16'h0000, 32'h0000_0000);
    offer_item(ActToCoords, 16'h0000, 16'h0000, 32'h0000_0003);
    offer_item(ActToCoords, 16'h0000, 16'h0000, 32'h0000_0002);

    // Random phases, each at its own order. Most items stay inside the
    // grid; the rest carry set bits above the mask.
    for (int p = 0; p < 10; p++) begin
      ord = (p < 6) ? phase_orders[p] : $urandom_range(0, 31);
      write_grid_order(ord[OrderBits-1:0]);
      sender_steady = (p == 2);
      eff   = (ord > MaxOrder) ? MaxOrder : ord;
      cmask = (64'd1 << eff) - 1;
      imask = (64'd1 << (2 * eff)) - 1;
      repeat (185) begin
        act = 1'($urandom_range(0, 1));
        rx  = $urandom;
        ry  = $urandom;
        rd  = $urandom;
        if ($urandom_range(0, 9) < 7) begin
          rx = rx & cmask[31:0];
          ry = ry & cmask[31:0];
          rd = rd & imask[31:0];
        end
        offer_item(act, rx[CoordBits-1:0], ry[CoordBits-1:0], rd);
      end
    end
    sender_steady = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("covered %0d items (%0d to index, %0d to coordinates), %0d results checked",
             items_sent, to_index_cnt, to_coords_cnt, results_seen);
    $display("grid order written %0d times incl. 0, 1, 16 and saturating values; %0d bad",
             order_writes, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
